/* design/dxmrg_pkg.sv */
// ----------------------------------------------------------------------------
// dxmrg_pkg
// Shared widths, constants, register indexes and types of the DX-K-S
// multiple recursive generator.
// ----------------------------------------------------------------------------
package dxmrg_pkg;

   localparam int VALUE_W    = 31;
   localparam int ORDER_W    = 16;
   localparam int MODE_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_MAX_ORDER = 2048;

   localparam logic [VALUE_W-1:0]   MOD_P      = 31'h7FFF_FFFF;
   localparam logic [VALUE_W+1:0]   MOD_P_WIDE = {2'b00, MOD_P};
   localparam logic [VALUE_W+1:0]   TWICE_P    = {1'b0, MOD_P, 1'b0};
   localparam logic [VALUE_W-1:0]   LCG_MUL    = 31'd1664525;
   localparam logic [VALUE_W-1:0]   LCG_ADD    = 31'd1013904223;
   localparam logic [ORDER_W-1:0]   FALLBACK_ORDER = 16'd1597;
   localparam logic [ORDER_W-1:0]   MIN_ORDER      = 16'd5;

   // Reciprocal of three scaled by 2^17, exact for values below 2^17.
   localparam int RECIP_THREE = 43691;
   localparam int RECIP_SHIFT = 17;

   localparam logic [ORDER_W-1:0] RESET_ORDER      = 16'd9;
   localparam logic [MODE_W-1:0]  RESET_MODE       = 4'd1;
   localparam logic [VALUE_W-1:0] RESET_MULT_ONE   = 31'd2097101;
   localparam logic [VALUE_W-1:0] RESET_MULT_TWO   = 31'd65011712;
   localparam logic [VALUE_W-1:0] RESET_MULT_THREE = 31'd67633152;
   localparam logic [VALUE_W-1:0] RESET_MULT_FOUR  = 31'd67108736;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_THREE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_FOUR  = 3'd5;

   // Request action codes.
   localparam logic ACTION_GENERATE = 1'b0;
   localparam logic ACTION_SEED     = 1'b1;

   // Mode register codes.
   localparam logic [MODE_W-1:0] MODE_TWO   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_THREE = 4'd3;
   localparam logic [MODE_W-1:0] MODE_FOUR  = 4'd4;

   // Effective mode, stored as the number of terms less one.
   localparam logic [1:0] SEL_ONE   = 2'd0;
   localparam logic [1:0] SEL_TWO   = 2'd1;
   localparam logic [1:0] SEL_THREE = 2'd2;
   localparam logic [1:0] SEL_FOUR  = 2'd3;

   // One operation of the shared unit: (a * b + c) mod P.
   typedef struct packed {
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
      logic [VALUE_W-1:0] c;
   } op_type;

endpackage

/* design/dxmrg_req_if.sv */
// ----------------------------------------------------------------------------
// dxmrg_req_if
// Request channel: generate or reseed, with the seed value.
// ----------------------------------------------------------------------------
interface dxmrg_req_if;
   import dxmrg_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [VALUE_W-1:0] seed_value;

   modport source (output valid, output action, output seed_value, input ready);
   modport sink   (input valid, input action, input seed_value, output ready);

endinterface

/* design/dxmrg_rsp_if.sv */
// ----------------------------------------------------------------------------
// dxmrg_rsp_if
// Result channel: one random value per generate request.
// ----------------------------------------------------------------------------
interface dxmrg_rsp_if;
   import dxmrg_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

/* design/dxmrg_csr_if.sv */
// ----------------------------------------------------------------------------
// dxmrg_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dxmrg_csr_if;
   import dxmrg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

/* design/dxmrg_modmul.sv */
// ----------------------------------------------------------------------------
// dxmrg_modmul
// Shared three-stage unit computing (a * b + c) mod 2^31-1.
// ----------------------------------------------------------------------------
module dxmrg_modmul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  dxmrg_pkg::op_type               op,
   output logic                            done,
   output logic [dxmrg_pkg::VALUE_W-1:0]   result
);
   import dxmrg_pkg::*;

   logic [2*VALUE_W-1:0] prod_ff, prod_in;
   logic [VALUE_W-1:0]   addend_ff, addend_in;
   logic [VALUE_W+1:0]   fold_ff, fold_in;
   logic [VALUE_W-1:0]   result_ff, result_in;
   logic [2:0]           stage_ff, stage_in;
   logic [VALUE_W+1:0]   reduced;

   assign prod_in   = (2*VALUE_W)'(op.a) * (2*VALUE_W)'(op.b);
   assign addend_in = op.c;

   // Since 2^31 is 1 mod P, the high half folds onto the low half.
   assign fold_in = (VALUE_W+2)'(prod_ff[2*VALUE_W-1:VALUE_W])
                  + (VALUE_W+2)'(prod_ff[VALUE_W-1:0])
                  + (VALUE_W+2)'(addend_ff);

   // The folded sum stays below 3P, so at most two subtractions are needed.
   always_comb begin
      if (fold_ff >= TWICE_P) begin
         reduced = fold_ff - TWICE_P;
      end else if (fold_ff >= MOD_P_WIDE) begin
         reduced = fold_ff - MOD_P_WIDE;
      end else begin
         reduced = fold_ff;
      end
   end

   assign result_in = reduced[VALUE_W-1:0];
   assign stage_in  = {stage_ff[1:0], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      addend_ff <= addend_in;
      fold_ff   <= fold_in;
      result_ff <= result_in;
   end

   assign done   = stage_ff[2];
   assign result = result_ff;

endmodule

/* design/dxmrg_ring.sv */
// ----------------------------------------------------------------------------
// dxmrg_ring
// Ring memory of generator state: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dxmrg_ring #(
   parameter int DEPTH = dxmrg_pkg::DEFAULT_MAX_ORDER
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [dxmrg_pkg::VALUE_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [dxmrg_pkg::VALUE_W-1:0] rd_data
);
   import dxmrg_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dx_multiple_recursive_rng_core.sv */
// ----------------------------------------------------------------------------
// dx_multiple_recursive_rng_core
// DX-K-S multiple recursive generator modulo 2^31-1 built around one shared
// multiply-and-reduce unit and a ring memory under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   req_bus   in         action (generate or reseed), seed_value
//   rsp_bus   out        value, one per generate request
//   csr_bus   in         index, data (order, mode, four multipliers)
//
// A generate request reads its terms from the ring, and the three-stage modular
// unit sums them and applies the multiplier before the result register is
// loaded; a reseed runs one LCG step per entry plus the discarded one. Reset
// is synchronous and restores the registers, indices and sequencer; the ring
// is filled by a reseed. Requests are accepted only when idle, and a finished
// result waits until the output is free.
//
module dx_multiple_recursive_rng_core #(
   parameter int MAX_ORDER = dxmrg_pkg::DEFAULT_MAX_ORDER
) (
   input logic        clock,
   input logic        reset,
   dxmrg_req_if.sink  req_bus,
   dxmrg_rsp_if.source rsp_bus,
   dxmrg_csr_if.sink  csr_bus
);
   import dxmrg_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ORDER);
   localparam int PROD_W = ORDER_W + RECIP_SHIFT + 1;

   // Term positions in the read sequence of a generate request.
   localparam logic [1:0] TERM_NEW   = 2'd0;
   localparam logic [1:0] TERM_OLD   = 2'd1;
   localparam logic [1:0] TERM_TAP   = 2'd2;
   localparam logic [1:0] TERM_THIRD = 2'd3;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_SEED_ISSUE = 8'b0000_0010,
      ST_SEED_WAIT  = 8'b0000_0100,
      ST_GEN_RD     = 8'b0000_1000,
      ST_GEN_USE    = 8'b0001_0000,
      ST_GEN_WAIT   = 8'b0010_0000,
      ST_GEN_MUL    = 8'b0100_0000,
      ST_GEN_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [VALUE_W-1:0] mult_one_ff, mult_one_in;
   logic [VALUE_W-1:0] mult_two_ff, mult_two_in;
   logic [VALUE_W-1:0] mult_three_ff, mult_three_in;
   logic [VALUE_W-1:0] mult_four_ff, mult_four_in;

   // Generator state.
   logic [IDX_W-1:0]   run_index_ff, run_index_in;
   logic [IDX_W-1:0]   tap_half_ff, tap_half_in;
   logic [IDX_W-1:0]   tap_two_thirds_ff, tap_two_thirds_in;
   logic [IDX_W-1:0]   tap_one_third_ff, tap_one_third_in;
   logic [VALUE_W-1:0] lcg_ff, lcg_in;

   // Working registers of the sequencer.
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [1:0]         sel_ff, sel_in;
   logic [1:0]         term_ff, term_in;
   logic               final_ff, final_in;
   logic               first_ff, first_in;
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_load;

   // Shared unit and ring connections.
   logic               issue;
   op_type             op;
   logic               unit_done;
   logic [VALUE_W-1:0] unit_result;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // Derived values.
   logic [ORDER_W-1:0]       k_eff;
   logic [ORDER_W-1:0]       k_minus_one;
   logic [PROD_W-1:0]        third_prod;
   logic [PROD_W-1:0]        two_thirds_prod;
   logic [PROD_W-RECIP_SHIFT-1:0] k_third;
   logic [PROD_W-RECIP_SHIFT-1:0] k_two_thirds;
   logic [1:0]               mode_sel;
   logic [IDX_W-1:0]         term_addr;
   logic [VALUE_W-1:0]       mult_sel;
   logic                     fill_last;

   // Step an index by one, wrapping to zero at the ring length.
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [ORDER_W-1:0] k);
      logic [ORDER_W:0] nxt;
      nxt = (ORDER_W+1)'(idx) + 1'b1;
      return (nxt >= {1'b0, k}) ? '0 : IDX_W'(nxt);
   endfunction

   // An order outside the supported range falls back to the length FALLBACK_ORDER.
   always_comb begin
      if (order_ff < MIN_ORDER || (ORDER_W+1)'(order_ff) > (ORDER_W+1)'(MAX_ORDER)) begin
         k_eff = FALLBACK_ORDER;
      end else begin
         k_eff = order_ff;
      end
   end

   assign k_minus_one     = k_eff - 1'b1;
   assign third_prod      = PROD_W'(k_eff) * PROD_W'(RECIP_THREE);
   assign two_thirds_prod = PROD_W'({k_eff, 1'b0}) * PROD_W'(RECIP_THREE);
   assign k_third         = third_prod[PROD_W-1:RECIP_SHIFT];
   assign k_two_thirds    = two_thirds_prod[PROD_W-1:RECIP_SHIFT];
   assign fill_last       = ((ORDER_W+1)'(fill_ff) == {1'b0, k_minus_one});

   // Any mode code other than two, three or four behaves as mode one.
   always_comb begin
      unique case (mode_ff)
         MODE_TWO:   mode_sel = SEL_TWO;
         MODE_THREE: mode_sel = SEL_THREE;
         MODE_FOUR:  mode_sel = SEL_FOUR;
         default:    mode_sel = SEL_ONE;
      endcase
   end

   // Ring address of each term. The third term is the half tap in mode three
   // and the two-thirds tap in mode four.
   always_comb begin
      case (term_ff)
         TERM_NEW:   term_addr = run_index_ff;
         TERM_OLD:   term_addr = old_idx_ff;
         TERM_TAP:   term_addr = (sel_ff == SEL_FOUR) ? tap_two_thirds_ff : tap_half_ff;
         TERM_THIRD: term_addr = tap_one_third_ff;
         default:    term_addr = run_index_ff;
      endcase
   end

   always_comb begin
      case (sel_ff)
         SEL_TWO:   mult_sel = mult_two_ff;
         SEL_THREE: mult_sel = mult_three_ff;
         default:   mult_sel = mult_four_ff;
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      order_in          = order_ff;
      mode_in           = mode_ff;
      mult_one_in       = mult_one_ff;
      mult_two_in       = mult_two_ff;
      mult_three_in     = mult_three_ff;
      mult_four_in      = mult_four_ff;
      run_index_in      = run_index_ff;
      tap_half_in       = tap_half_ff;
      tap_two_thirds_in = tap_two_thirds_ff;
      tap_one_third_in  = tap_one_third_ff;
      lcg_in            = lcg_ff;
      old_idx_in        = old_idx_ff;
      sel_in            = sel_ff;
      term_in           = term_ff;
      final_in          = final_ff;
      first_in          = first_ff;
      fill_in           = fill_ff;
      acc_in            = acc_ff;
      rsp_value_in      = rsp_value_ff;
      rsp_load          = 1'b0;
      issue             = 1'b0;
      op                = '{a: '0, b: '0, c: '0};
      rd_en             = 1'b0;
      rd_addr           = term_addr;
      wr_en             = 1'b0;
      wr_addr           = fill_ff;
      wr_data           = unit_result;

      // The configuration port is always ready; indexes past the list are ignored.
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ORDER:      order_in      = csr_bus.data[ORDER_W-1:0];
            CSR_MODE:       mode_in       = csr_bus.data[MODE_W-1:0];
            CSR_MULT_ONE:   mult_one_in   = csr_bus.data[VALUE_W-1:0];
            CSR_MULT_TWO:   mult_two_in   = csr_bus.data[VALUE_W-1:0];
            CSR_MULT_THREE: mult_three_in = csr_bus.data[VALUE_W-1:0];
            CSR_MULT_FOUR:  mult_four_in  = csr_bus.data[VALUE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.action == ACTION_SEED) begin
                  lcg_in            = req_bus.seed_value;
                  first_in          = 1'b1;
                  fill_in           = '0;
                  run_index_in      = IDX_W'(k_minus_one);
                  tap_half_in       = IDX_W'(k_eff[ORDER_W-1:1] - 1'b1);
                  tap_two_thirds_in = IDX_W'(k_two_thirds - 1'b1);
                  tap_one_third_in  = IDX_W'(k_third - 1'b1);
                  state_in          = ST_SEED_ISSUE;
               end else begin
                  // Indices move on at acceptance; the reads below see the new values.
                  sel_in       = mode_sel;
                  old_idx_in   = run_index_ff;
                  run_index_in = advance(run_index_ff, k_eff);
                  if (mode_sel == SEL_THREE) begin
                     tap_half_in = advance(tap_half_ff, k_eff);
                  end
                  if (mode_sel == SEL_FOUR) begin
                     tap_two_thirds_in = advance(tap_two_thirds_ff, k_eff);
                     tap_one_third_in  = advance(tap_one_third_ff, k_eff);
                  end
                  term_in  = TERM_NEW;
                  state_in = ST_GEN_RD;
               end
            end
         end

         ST_SEED_ISSUE: begin
            issue    = 1'b1;
            op       = '{a: LCG_MUL, b: lcg_ff, c: LCG_ADD};
            state_in = ST_SEED_WAIT;
         end

         ST_SEED_WAIT: begin
            if (unit_done) begin
               lcg_in = unit_result;
               if (first_ff) begin
                  // The first step after loading the seed is thrown away.
                  first_in = 1'b0;
                  state_in = ST_SEED_ISSUE;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = fill_ff;
                  wr_data = unit_result;
                  if (fill_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     fill_in  = fill_ff + 1'b1;
                     state_in = ST_SEED_ISSUE;
                  end
               end
            end
         end

         ST_GEN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = term_addr;
            state_in = ST_GEN_USE;
         end

         ST_GEN_USE: begin
            if (term_ff == TERM_NEW) begin
               acc_in   = rd_data;
               term_in  = TERM_OLD;
               state_in = ST_GEN_RD;
            end else if (sel_ff == SEL_ONE) begin
               // Mode one needs a single pass: B1 times the new entry plus the old.
               issue    = 1'b1;
               op       = '{a: mult_one_ff, b: acc_ff, c: rd_data};
               final_in = 1'b1;
               state_in = ST_GEN_WAIT;
            end else begin
               // Accumulate the term as rd_data * 1 + acc.
               issue    = 1'b1;
               op       = '{a: rd_data, b: VALUE_W'(1), c: acc_ff};
               final_in = 1'b0;
               state_in = ST_GEN_WAIT;
            end
         end

         ST_GEN_WAIT: begin
            if (unit_done) begin
               acc_in = unit_result;
               if (final_ff) begin
                  state_in = ST_GEN_OUT;
               end else if (term_ff == sel_ff) begin
                  state_in = ST_GEN_MUL;
               end else begin
                  term_in  = term_ff + 1'b1;
                  state_in = ST_GEN_RD;
               end
            end
         end

         ST_GEN_MUL: begin
            issue    = 1'b1;
            op       = '{a: mult_sel, b: acc_ff, c: '0};
            final_in = 1'b1;
            state_in = ST_GEN_WAIT;
         end

         ST_GEN_OUT: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_value_in = acc_ff;
               wr_en        = 1'b1;
               wr_addr      = run_index_ff;
               wr_data      = acc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         order_ff          <= RESET_ORDER;
         mode_ff           <= RESET_MODE;
         mult_one_ff       <= RESET_MULT_ONE;
         mult_two_ff       <= RESET_MULT_TWO;
         mult_three_ff     <= RESET_MULT_THREE;
         mult_four_ff      <= RESET_MULT_FOUR;
         run_index_ff      <= '0;
         tap_half_ff       <= '0;
         tap_two_thirds_ff <= '0;
         tap_one_third_ff  <= '0;
         lcg_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         order_ff          <= order_in;
         mode_ff           <= mode_in;
         mult_one_ff       <= mult_one_in;
         mult_two_ff       <= mult_two_in;
         mult_three_ff     <= mult_three_in;
         mult_four_ff      <= mult_four_in;
         run_index_ff      <= run_index_in;
         tap_half_ff       <= tap_half_in;
         tap_two_thirds_ff <= tap_two_thirds_in;
         tap_one_third_ff  <= tap_one_third_in;
         lcg_ff            <= lcg_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_idx_ff   <= old_idx_in;
      sel_ff       <= sel_in;
      term_ff      <= term_in;
      final_ff     <= final_in;
      first_ff     <= first_in;
      fill_ff      <= fill_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   dxmrg_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .op     (op),
      .done   (unit_done),
      .result (unit_result)
   );

   dxmrg_ring #(
      .DEPTH (MAX_ORDER)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign csr_bus.ready = 1'b1;

endmodule

/* test/dxmrg_stream_checker.sv */
// ----------------------------------------------------------------------------
// dxmrg_stream_checker
// Watches the request, result and configuration channels of the DX-K-S
// generator, keeps its own copy of the ring, indices and registers, and
// compares every result with the value it predicts.
// ----------------------------------------------------------------------------
module dxmrg_stream_checker #(
   parameter int MAX_ORDER = dxmrg_pkg::DEFAULT_MAX_ORDER
) (
   input  logic        clock,
   input  logic        reset,
   dxmrg_req_if        req_mon,
   dxmrg_rsp_if        rsp_mon,
   dxmrg_csr_if        csr_mon,
   output int unsigned fault_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);
   import dxmrg_pkg::*;

   localparam int              IDX_W        = $clog2(MAX_ORDER);
   localparam int unsigned     REPORT_LIMIT = 10;
   localparam longint unsigned PRIME        = MOD_P;

   typedef logic [IDX_W-1:0] slot_type;

   logic [ORDER_W-1:0] order_reg;
   logic [MODE_W-1:0]  mode_reg;
   logic [VALUE_W-1:0] mult_one;
   logic [VALUE_W-1:0] mult_two;
   logic [VALUE_W-1:0] mult_three;
   logic [VALUE_W-1:0] mult_four;

   logic [VALUE_W-1:0] ring [MAX_ORDER];
   slot_type           cursor;
   slot_type           tap_mid;
   slot_type           tap_hi;
   slot_type           tap_lo;
   logic [VALUE_W-1:0] lcg_state;

   logic [VALUE_W-1:0] expected_values [$];
   logic [VALUE_W-1:0] want;

   function automatic int unsigned ring_length();
      if (order_reg < MIN_ORDER || order_reg > MAX_ORDER)
         return FALLBACK_ORDER;
      return order_reg;
   endfunction

   function automatic slot_type wrap_next(slot_type idx, int unsigned k);
      int unsigned nxt;
      nxt = idx + 1;
      return (nxt >= k) ? '0 : slot_type'(nxt);
   endfunction

   function automatic logic [VALUE_W-1:0] mul_add_mod(longint unsigned a, longint unsigned b,
                                                      longint unsigned c);
      return VALUE_W'((a * b + c) % PRIME);
   endfunction

   // A reseed discards one LCG step, then fills entries 0 to K-1.
   task automatic reseed_ring(logic [VALUE_W-1:0] seed);
      int unsigned k;
      int unsigned slot;
      k = ring_length();
      lcg_state = mul_add_mod(LCG_MUL, seed, LCG_ADD);
      for (slot = 0; slot < k; slot++) begin
         lcg_state  = mul_add_mod(LCG_MUL, lcg_state, LCG_ADD);
         ring[slot] = lcg_state;
      end
      cursor  = slot_type'(k - 1);
      tap_mid = slot_type'(k / 2 - 1);
      tap_hi  = slot_type'(2 * k / 3 - 1);
      tap_lo  = slot_type'(k / 3 - 1);
   endtask

   function automatic logic [VALUE_W-1:0] next_random_value();
      int unsigned        k;
      slot_type           prev;
      longint unsigned    total;
      longint unsigned    scale;
      logic [VALUE_W-1:0] result;
      k      = ring_length();
      prev   = cursor;
      cursor = wrap_next(cursor, k);
      case (mode_reg)
         MODE_TWO: begin
            total = longint'(ring[cursor]) + ring[prev];
            scale = mult_two;
         end
         MODE_THREE: begin
            tap_mid = wrap_next(tap_mid, k);
            total   = longint'(ring[cursor]) + ring[tap_mid] + ring[prev];
            scale   = mult_three;
         end
         MODE_FOUR: begin
            tap_hi = wrap_next(tap_hi, k);
            tap_lo = wrap_next(tap_lo, k);
            total  = longint'(ring[cursor]) + ring[tap_hi] + ring[tap_lo] + ring[prev];
            scale  = mult_four;
         end
         default: begin
            // Mode one, and every mode code outside the four terms.
            total = (longint'(mult_one) * ring[cursor]) % PRIME + ring[prev];
            scale = 1;
         end
      endcase
      result       = mul_add_mod(total % PRIME, scale, 0);
      ring[cursor] = result;
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         order_reg     = RESET_ORDER;
         mode_reg      = RESET_MODE;
         mult_one      = RESET_MULT_ONE;
         mult_two      = RESET_MULT_TWO;
         mult_three    = RESET_MULT_THREE;
         mult_four     = RESET_MULT_FOUR;
         cursor        = '0;
         tap_mid       = '0;
         tap_hi        = '0;
         tap_lo        = '0;
         lcg_state     = '0;
         fault_count   = 0;
         checked_count = 0;
         expected_values.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_values.size() == 0) begin
               if (fault_count < REPORT_LIMIT)
                  $display("[%0t] result %0d arrived with no request outstanding",
                           $time, rsp_mon.value);
               fault_count++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_mon.value !== want) begin
                  if (fault_count < REPORT_LIMIT)
                     $display("[%0t] result %0d: value expected %0d, got %0d",
                              $time, checked_count, want, rsp_mon.value);
                  fault_count++;
               end
               checked_count++;
            end
         end
         if (csr_mon.valid === 1'b1 && csr_mon.ready === 1'b1) begin
            case (csr_mon.index)
               CSR_ORDER:      order_reg  = csr_mon.data[ORDER_W-1:0];
               CSR_MODE:       mode_reg   = csr_mon.data[MODE_W-1:0];
               CSR_MULT_ONE:   mult_one   = csr_mon.data[VALUE_W-1:0];
               CSR_MULT_TWO:   mult_two   = csr_mon.data[VALUE_W-1:0];
               CSR_MULT_THREE: mult_three = csr_mon.data[VALUE_W-1:0];
               CSR_MULT_FOUR:  mult_four  = csr_mon.data[VALUE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.action == ACTION_SEED)
               reseed_ring(req_mon.seed_value);
            else
               expected_values.push_back(next_random_value());
         end
      end
      pending_count = expected_values.size();
   end

endmodule

/* test/dx_multiple_recursive_rng_core_tb.sv */
// ----------------------------------------------------------------------------
// dx_multiple_recursive_rng_core_tb
// Drives generate and reseed requests and register writes into the DX-K-S
// generator under random back-pressure, while a separate checker predicts and
// compares every random value that comes back.
// ----------------------------------------------------------------------------
module dx_multiple_recursive_rng_core_tb;
   import dxmrg_pkg::*;

   localparam int MAX_ORDER       = DEFAULT_MAX_ORDER;
   localparam int RANDOM_REQUESTS = 1026;
   // The slowest quiet stretch is a full-size reseed; the limit lies well beyond it.
   localparam int STALL_LIMIT     = 60000;

   localparam logic [MODE_W-1:0]    MODE_ONE     = 4'd1;
   // Indexes that no register answers to; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;

   // Percentages of cycles in which the sender or the receiver holds back.
   int req_gap_pct = 14;
   int rsp_gap_pct = 48;

   // What the stimulus needs to know to stay legal: the order register, and
   // how much of the ring has been written by reseeds so far.
   logic [ORDER_W-1:0] cur_order;
   logic               seeded;
   logic               last_was_seed;
   int unsigned        ring_filled;
   int unsigned        last_seed_k;

   int unsigned seed_count      = 0;
   int unsigned generate_count  = 0;
   int unsigned csr_write_count = 0;
   int unsigned idle_cycles     = 0;

   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned checked_count;

   dxmrg_req_if req_bus ();
   dxmrg_rsp_if rsp_bus ();
   dxmrg_csr_if csr_bus ();

   dx_multiple_recursive_rng_core #(
      .MAX_ORDER(MAX_ORDER)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   dxmrg_stream_checker #(
      .MAX_ORDER(MAX_ORDER)
   ) stream_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fault_count  (fault_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides afresh at every falling edge whether it will take a
   // result, so its stalls land on every phase of the block's work.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   // The watchdog ends the run when no request, result or register write has
   // been accepted for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: nothing accepted for %0d cycles, %0d results still due.",
                  STALL_LIMIT, pending_count);
         $display("dx_multiple_recursive_rng_core test failed");
         $finish;
      end
   end

   // Ring length that an order setting gives; out-of-range values fall back.
   function automatic int unsigned ring_length(logic [ORDER_W-1:0] order);
      if (order < MIN_ORDER || order > MAX_ORDER)
         return FALLBACK_ORDER;
      return order;
   endfunction

   // Presents one request, starting and ending at a falling edge. Valid stays
   // high into the next request unless the sender chooses to pause, and the
   // fields carry noise while valid is low.
   task automatic send_request(logic act, logic [VALUE_W-1:0] seed);
      int unsigned k;
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.action     <= 1'($urandom);
         req_bus.seed_value <= VALUE_W'($urandom);
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.seed_value <= seed;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      if (act == ACTION_SEED) begin
         k           = ring_length(cur_order);
         seeded      = 1'b1;
         last_seed_k = k;
         if (k > ring_filled)
            ring_filled = k;
         seed_count++;
      end else begin
         generate_count++;
      end
      last_was_seed = (act == ACTION_SEED);
   endtask

   // Writes one register, starting and ending at a falling edge with valid low.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
      if (idx == CSR_ORDER)
         cur_order = data[ORDER_W-1:0];
      csr_write_count++;
   endtask

   // Brings the block to rest: every expected result has arrived and, since a
   // reseed returns nothing, a trailing reseed has had time to fill the ring.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (last_was_seed ? 4 * (last_seed_k + 1) + 8 : 8)
         @(negedge clock);
   endtask

   // One random stretch: new settings, usually a fresh reseed, then a run of
   // requests that are mostly generates with the odd reseed in between.
   task automatic run_segment();
      logic [CSR_DATA_W-1:0] noise;
      logic [ORDER_W-1:0]    ord;
      logic [VALUE_W-1:0]    mult;
      int unsigned           pick;
      int unsigned           slot;
      int unsigned           k;
      int unsigned           length;
      noise = $urandom;
      pick  = $urandom_range(99);
      // Short rings dominate, since a reseed runs one LCG step per entry.
      if (pick < 78)
         ord = ORDER_W'($urandom_range(MIN_ORDER, 32));
      else if (pick < 88)
         ord = ORDER_W'($urandom_range(33, 300));
      else if (pick < 94)
         ord = $urandom_range(1) ? ORDER_W'($urandom_range(MIN_ORDER - 1))
                                 : ORDER_W'($urandom_range(MAX_ORDER + 1, 65535));
      else
         ord = ORDER_W'($urandom_range(1500, MAX_ORDER));
      if ($urandom_range(3) != 0)
         write_csr(CSR_ORDER, {noise[31:ORDER_W], ord});
      if ($urandom_range(3) != 0)
         write_csr(CSR_MODE, {noise[31:MODE_W],
                              ($urandom_range(4) != 0) ?
                                 MODE_W'($urandom_range(MODE_ONE, MODE_FOUR)) :
                                 MODE_W'($urandom)});
      for (slot = 0; slot < 4; slot++) begin
         if ($urandom_range(2) == 0) begin
            pick = $urandom_range(9);
            mult = (pick == 0) ? '0 : (pick == 1) ? MOD_P : VALUE_W'($urandom);
            write_csr(CSR_IDX_W'(CSR_MULT_ONE + slot), {noise[31], mult});
         end
      end
      // A ring longer than what has been written must be reseeded before any
      // generate, so that no entry is read before it holds a value.
      k = ring_length(cur_order);
      if (!seeded || k > ring_filled || $urandom_range(9) < 8)
         send_request(ACTION_SEED, VALUE_W'($urandom));
      length = $urandom_range(20, 50);
      repeat (length) begin
         if (k <= 64 && $urandom_range(19) == 0)
            send_request(ACTION_SEED, VALUE_W'($urandom));
         else
            send_request(ACTION_GENERATE, VALUE_W'($urandom));
      end
      settle();
   endtask

   initial begin
      int unsigned goal;
      int          phase;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACTION_GENERATE;
      req_bus.seed_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_ORDER;
      csr_bus.data       = '0;
      cur_order          = RESET_ORDER;
      seeded             = 1'b0;
      last_was_seed      = 1'b0;
      ring_filled        = 0;
      last_seed_k        = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The reset settings come first: a zero seed, then two
      // numbers in mode one.
      send_request(ACTION_SEED, '0);
      send_request(ACTION_GENERATE, '0);
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // Each mode in turn, then the two extreme mode codes, which both fall
      // back to a single term.
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_TWO));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_THREE));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_FOUR));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MODE, '1);
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MODE, '0);
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // A seed of all ones, which equals the modulus itself.
      send_request(ACTION_SEED, MOD_P);

      // Shrinking the ring after seeding: the running index and the outer tap
      // sit beyond the new length and must wrap to zero on their next advance.
      settle();
      write_csr(CSR_ORDER, CSR_DATA_W'(MIN_ORDER));
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_FOUR));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // The shortest legal ring, run long enough to wrap the running index and the outer tap.
      send_request(ACTION_SEED, VALUE_W'($urandom));
      repeat (4) send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // Multipliers equal to the modulus, then multipliers of zero.
      settle();
      write_csr(CSR_MULT_ONE, '1);
      write_csr(CSR_MULT_TWO, '1);
      write_csr(CSR_MULT_THREE, '1);
      write_csr(CSR_MULT_FOUR, '1);
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_THREE));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MULT_ONE, '0);
      write_csr(CSR_MULT_TWO, '0);
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_TWO));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_ONE));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // The largest order value falls back to the ring length FALLBACK_ORDER.
      settle();
      write_csr(CSR_MULT_ONE, CSR_DATA_W'($urandom));
      write_csr(CSR_MULT_TWO, CSR_DATA_W'($urandom));
      write_csr(CSR_ORDER, '1);
      send_request(ACTION_SEED, VALUE_W'($urandom));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // The full ring, in mode four.
      settle();
      write_csr(CSR_ORDER, CSR_DATA_W'(MAX_ORDER));
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_FOUR));
      send_request(ACTION_SEED, VALUE_W'($urandom));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));

      // Writes to unused indexes, then an order just below the minimum, which
      // also falls back; the ring written above covers every index it reads.
      settle();
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '1);
      write_csr(CSR_ORDER, CSR_DATA_W'(MIN_ORDER - 1));
      send_request(ACTION_GENERATE, VALUE_W'($urandom));
      settle();

      // Random part, in three stretches of back-pressure: a slow receiver,
      // then a slow sender, then neither holding back.
      goal = seed_count + generate_count;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct = 14;
               rsp_gap_pct = 48;
            end
            1: begin
               req_gap_pct = 48;
               rsp_gap_pct = 14;
            end
            default: begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         goal += RANDOM_REQUESTS / 3;
         while (seed_count + generate_count < goal)
            run_segment();
      end

      settle();
      $display("Run covered %0d generate and %0d reseed requests, %0d results compared,",
               generate_count, seed_count, checked_count);
      $display("with %0d register writes; rings of %0d up to %0d entries were seeded.",
               csr_write_count, MIN_ORDER, ring_filled);
      if (fault_count == 0)
         $display("dx_multiple_recursive_rng_core test passed");
      else
         $display("dx_multiple_recursive_rng_core test failed");
      $finish;
   end

endmodule
